>>> rtl/domain_name_syntax_checker_defines.svh
// assertion macros shared by the rtl of the name syntax checker
`ifndef DOMAIN_NAME_SYNTAX_CHECKER_DEFINES_SVH
`define DOMAIN_NAME_SYNTAX_CHECKER_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define DNSC_ASSERT_NOW(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error(msg);

// condition must hold in the cycle after the trigger
`define DNSC_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

>>> rtl/dnsc_pkg.sv
// types and constants of the name syntax checker
package dnsc_pkg;

   typedef enum logic [3:0] {
      PH_P0         = 4'd0,
      PH_P1         = 4'd1,
      PH_P2         = 4'd2,
      PH_P3         = 4'd3,
      PH_P4         = 4'd4,
      PH_P5         = 4'd5,
      PH_P6         = 4'd6,
      PH_P7         = 4'd7,
      PH_PREFIX_DONE = 4'd8,
      PH_IN_NAME    = 4'd9,
      PH_WANT_SLASH = 4'd10,
      PH_ESC_FIRST  = 4'd11,
      PH_ESC_SECOND = 4'd12,
      PH_ESC_THIRD  = 4'd13
   } phase_type;

   localparam int PrefixLen = 8;

   localparam logic [7:0] ROOT_PREFIX [PrefixLen] = '{
      8'h3c, 8'h6b, 8'h65, 8'h72, 8'h6e, 8'h65, 8'h6c, 8'h3e
   };

   localparam logic [7:0] CHAR_TERM      = 8'h00;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_SLASH     = 8'h2f;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_THREE     = 8'h33;
   localparam logic [7:0] CHAR_SEVEN     = 8'h37;
   localparam logic [7:0] CHAR_DEL       = 8'h7f;

   // one byte handed from the input register to the parser
   typedef struct packed {
      logic       go;
      logic [7:0] char_byte;
   } step_type;

endpackage

>>> rtl/dnsc_parser.sv
// phase, escape and error state of the name parser with its next-state logic
`include "domain_name_syntax_checker_defines.svh"

module dnsc_parser
   import dnsc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  step_type step,
   output logic     name_ok
);

   phase_type   phase_ff, phase_in;
   logic [4:0]  octal_ff, octal_in;
   logic        error_ff, error_in;

   phase_type   phase_cand;
   logic [4:0]  octal_cand;
   logic        step_ok;
   logic        is_term;
   logic        is_octal;
   logic [2:0]  digit;
   logic [7:0]  esc_value;
   logic [7:0]  c;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_P0;
         octal_ff <= '0;
         error_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         octal_ff <= octal_in;
         error_ff <= error_in;
      end
   end

   always_comb begin
      c          = step.char_byte;
      is_term    = (c == CHAR_TERM);
      is_octal   = (c >= CHAR_ZERO) && (c <= CHAR_SEVEN);
      digit      = c[2:0];
      esc_value  = {octal_ff, digit};
      phase_cand = phase_ff;
      octal_cand = octal_ff;
      step_ok    = 1'b0;

      unique case (phase_ff) inside
         [PH_P0:PH_P7]: begin
            step_ok    = (c == ROOT_PREFIX[phase_ff[2:0]]);
            phase_cand = phase_type'(4'(phase_ff + 4'd1));
         end
         PH_PREFIX_DONE: begin
            step_ok    = (c == CHAR_SPACE);
            phase_cand = PH_WANT_SLASH;
         end
         PH_IN_NAME: begin
            if (c == CHAR_SPACE) begin
               step_ok    = 1'b1;
               phase_cand = PH_WANT_SLASH;
            end else if (c == CHAR_BACKSLASH) begin
               step_ok    = 1'b1;
               phase_cand = PH_ESC_FIRST;
            end else begin
               step_ok = (c > CHAR_SPACE) && (c < CHAR_DEL);
            end
         end
         PH_WANT_SLASH: begin
            step_ok    = (c == CHAR_SLASH);
            phase_cand = PH_IN_NAME;
         end
         PH_ESC_FIRST: begin
            if (c == CHAR_BACKSLASH) begin
               step_ok    = 1'b1;
               phase_cand = PH_IN_NAME;
            end else begin
               step_ok    = (c >= CHAR_ZERO) && (c <= CHAR_THREE);
               octal_cand = {3'b000, digit[1:0]};
               phase_cand = PH_ESC_SECOND;
            end
         end
         PH_ESC_SECOND: begin
            step_ok    = is_octal;
            octal_cand = {octal_ff[1:0], digit};
            phase_cand = PH_ESC_THIRD;
         end
         PH_ESC_THIRD: begin
            // escaped value must be nonzero and not printable
            step_ok    = is_octal && (esc_value != 8'd0) &&
                         !((esc_value > CHAR_SPACE) && (esc_value < CHAR_DEL));
            phase_cand = PH_IN_NAME;
         end
         default: begin
            step_ok = 1'b0;
         end
      endcase

      phase_in = phase_ff;
      octal_in = octal_ff;
      error_in = error_ff;
      name_ok  = !error_ff && ((phase_ff == PH_PREFIX_DONE) || (phase_ff == PH_IN_NAME));

      if (step.go) begin
         if (is_term) begin
            phase_in = PH_P0;
            octal_in = '0;
            error_in = 1'b0;
         end else if (!error_ff) begin
            if (step_ok) begin
               phase_in = phase_cand;
               octal_in = octal_cand;
            end else begin
               error_in = 1'b1;
            end
         end
      end
   end

   `DNSC_ASSERT_NEXT(a_term_restarts, step.go && (step.char_byte == CHAR_TERM),
      (phase_ff == PH_P0) && !error_ff && (octal_ff == 5'd0), "terminator did not restart")
   `DNSC_ASSERT_NEXT(a_error_sticky, error_ff && !(step.go && (step.char_byte == CHAR_TERM)),
      error_ff && $stable(phase_ff), "error cleared before terminator")
   `DNSC_ASSERT_NOW(a_esc_second_digits, phase_ff == PH_ESC_SECOND,
      octal_ff[4:2] == 3'b000, "first escape digit above three")

endmodule

>>> rtl/domain_name_syntax_checker.sv
// top level of the name syntax checker: input register, parser, result register
//
// Usage: names arrive one byte per transfer on the req_ channel (req_char_byte),
// each name closed by a zero byte. Every zero byte yields exactly one transfer on
// the rsp_ channel: rsp_name_valid is 1 when the finished name has the root
// prefix, then any space-slash groups of legal name characters and escapes.
// Other bytes yield no result.
// Throughput: one byte per cycle unless a terminator waits on a held result;
// the parser step between input register and result register is combinational.
// A terminator's result passes through the input register and then the result
// register, whose contents drive rsp_; a held result can hold it in the input register.
// Reset (synchronous, active high) empties both registers and returns the
// parser to the start of the prefix; req_stall is low afterwards.
// Stall: while rsp_stall holds a result, ordinary bytes still flow; only a
// following terminator waits in the input register, raising req_stall.
`include "domain_name_syntax_checker_defines.svh"

module domain_name_syntax_checker
   import dnsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_name_valid
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       out_valid_ff, out_valid_in;
   logic       out_name_ff, out_name_in;

   logic       in_term;
   logic       out_free;
   logic       in_go;
   logic       name_ok;
   step_type   step;

   assign in_term  = (in_byte_ff == CHAR_TERM);
   assign out_free = !out_valid_ff || !rsp_stall;
   // a terminator needs room in the result register, other bytes never wait
   assign in_go    = in_valid_ff && (!in_term || out_free);
   assign req_stall = in_valid_ff && !in_go;

   assign step.go        = in_go;
   assign step.char_byte = in_byte_ff;

   dnsc_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .name_ok (name_ok)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_byte_in  = req_char_byte;
      end

      out_valid_in = out_valid_ff && rsp_stall;
      out_name_in  = out_name_ff;
      if (in_go && in_term) begin
         out_valid_in = 1'b1;
         out_name_in  = name_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      out_name_ff <= out_name_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_name_valid = out_name_ff;

   `DNSC_ASSERT_NOW(a_stall_only_on_full, req_stall,
      in_term && out_valid_ff && rsp_stall, "input stalled without a blocked result")
   `DNSC_ASSERT_NEXT(a_term_gives_result, in_go && in_term,
      out_valid_ff, "terminator transfer produced no result")
   `DNSC_ASSERT_NEXT(a_no_stray_result, !out_valid_ff && !(in_go && in_term),
      !out_valid_ff, "result appeared without a terminator")

endmodule
